### rtl/sfb_pkg.sv
// Shared types, codes and CRC-8 helpers for the sensor frame builder.
// No dependencies; used by every module of the block but sfb_checker.
package sfb_pkg;

   // Request operation codes
   typedef enum logic [2:0] {
      OP_MEM_READ = 3'd0,
      OP_EE_WRITE = 3'd1,
      OP_NOP      = 3'd2,
      OP_GET1     = 3'd3,
      OP_CHECK    = 3'd4
   } op_type;

   // What the back end does with a queued entry
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_BUILD = 2'd1,
      KIND_CHECK = 2'd2
   } kind_type;

   // Configuration register indexes
   localparam logic [7:0] CSR_MEM_READ_CODE = 8'd0;
   localparam logic [7:0] CSR_EE_WRITE_CODE = 8'd1;
   localparam logic [7:0] CSR_NOP_CODE      = 8'd2;
   localparam logic [7:0] CSR_GET1_CODE     = 8'd3;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h2F;

   // EEPROM write keys, indexed by {addr[5:4], addr[3:1]}
   localparam logic [15:0] EE_KEY_ROM [0:31] = '{
      16'd17485, 16'd31053, 16'd57190, 16'd57724,
      16'd7899,  16'd53543, 16'd26763, 16'd12528,
      16'd38105, 16'd51302, 16'd16209, 16'd24847,
      16'd13134, 16'd52339, 16'd14530, 16'd18350,
      16'd55636, 16'd64477, 16'd40905, 16'd45498,
      16'd24411, 16'd36677, 16'd4213,  16'd48843,
      16'd6368,  16'd5907,  16'd31384, 16'd63325,
      16'd3562,  16'd19816, 16'd6995,  16'd3147
   };

   // One queued entry: bytes 0..6 of the frame plus the reply CRC byte
   typedef struct packed {
      kind_type    kind;
      logic [55:0] msg;
      logic [7:0]  rx_crc;
   } entry_type;

   // Fold one byte into the running CRC (MSB first, no reflection)
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

### rtl/sfb_front.sv
// Front end: holds the command code registers, classifies each request
// and lays out frame bytes 0..6. Depends on sfb_pkg.
module sfb_front import sfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request fields
   input  logic [2:0]  req_op,
   input  logic [15:0] req_addr0,
   input  logic [15:0] req_addr1,
   input  logic [15:0] req_word_value,
   input  logic [7:0]  req_message_type,
   input  logic [63:0] req_rx_frame,
   // configuration writes
   input  logic        csr_write,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   // entry toward the queue
   output entry_type   entry
);

   logic [7:0]  mem_read_code_ff;
   logic [7:0]  ee_write_code_ff;
   logic [7:0]  nop_code_ff;
   logic [7:0]  get1_code_ff;
   logic [15:0] ee_key;
   logic [7:0]  ee_addr;

   // Command code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mem_read_code_ff <= '0;
         ee_write_code_ff <= '0;
         nop_code_ff      <= '0;
         get1_code_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MEM_READ_CODE: mem_read_code_ff <= csr_data;
            CSR_EE_WRITE_CODE: ee_write_code_ff <= csr_data;
            CSR_NOP_CODE:      nop_code_ff      <= csr_data;
            CSR_GET1_CODE:     get1_code_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Key lookup: address bit 0 and bits 7:6 do not take part
   assign ee_addr = req_addr0[7:0];
   assign ee_key  = EE_KEY_ROM[{ee_addr[5:4], ee_addr[3:1]}];

   // Classify and lay out bytes 0..6 (byte 0 in bits 7:0)
   always_comb begin
      entry.kind   = KIND_NONE;
      entry.msg    = '0;
      entry.rx_crc = '0;
      unique case (op_type'(req_op))
         OP_MEM_READ: begin
            entry.kind = KIND_BUILD;
            entry.msg  = {mem_read_code_ff, 16'h0000, req_addr1, req_addr0};
         end
         OP_EE_WRITE: begin
            entry.kind = KIND_BUILD;
            entry.msg  = {ee_write_code_ff, req_word_value, ee_key,
                          2'b00, ee_addr[5:0], 8'h00};
         end
         OP_NOP: begin
            entry.kind = KIND_BUILD;
            entry.msg  = {nop_code_ff, 16'h0000, req_word_value, 16'h0000};
         end
         OP_GET1: begin
            entry.kind = KIND_BUILD;
            entry.msg  = {req_message_type | get1_code_ff, 16'h0000,
                          req_word_value[7:0], req_word_value[15:8], 16'h0000};
         end
         OP_CHECK: begin
            entry.kind   = KIND_CHECK;
            entry.msg    = req_rx_frame[55:0];
            entry.rx_crc = req_rx_frame[63:56];
         end
         default: ;
      endcase
   end

endmodule

### rtl/sfb_queue.sv
// Small register FIFO between the front and back ends.
// Depends on sfb_pkg for the entry type.
module sfb_queue import sfb_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   entry_type        store_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/sfb_back.sv
// Back end: two-stage CRC-8 pipeline and the response register.
// Depends on sfb_pkg.
module sfb_back import sfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // queue head
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tx_frame,
   output logic        rsp_crc_ok,
   output logic [13:0] rsp_angle_raw
);

   logic        s1_valid_ff;
   entry_type   s1_entry_ff;
   logic [7:0]  s1_crc_ff;
   logic [7:0]  s1_crc_in;

   logic        out_valid_ff;
   logic [63:0] tx_frame_ff;
   logic        crc_ok_ff;
   logic [13:0] angle_ff;
   logic [63:0] tx_frame_in;
   logic        crc_ok_in;
   logic [13:0] angle_in;
   logic [7:0]  crc_final;

   logic        out_load;
   logic        s1_load;

   assign out_load = !out_valid_ff || !rsp_stall;
   assign s1_load  = !s1_valid_ff || out_load;
   assign pop      = s1_load;

   // Stage 1: CRC over bytes 0..3
   always_comb begin
      s1_crc_in = CRC_INIT;
      for (int i = 0; i < 4; i++) begin
         s1_crc_in = crc8_byte(s1_crc_in, head_entry.msg[8*i +: 8]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_entry_ff <= head_entry;
         s1_crc_ff   <= s1_crc_in;
      end
   end

   // Stage 2: bytes 4..6, final inversion, result fields
   always_comb begin
      crc_final = s1_crc_ff;
      for (int i = 4; i < 7; i++) begin
         crc_final = crc8_byte(crc_final, s1_entry_ff.msg[8*i +: 8]);
      end
      crc_final = ~crc_final;

      tx_frame_in = '0;
      crc_ok_in   = 1'b0;
      angle_in    = '0;
      case (s1_entry_ff.kind)
         KIND_BUILD: tx_frame_in = {crc_final, s1_entry_ff.msg};
         KIND_CHECK: begin
            crc_ok_in = (crc_final == s1_entry_ff.rx_crc);
            angle_in  = {s1_entry_ff.msg[13:8], s1_entry_ff.msg[7:0]};
         end
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         tx_frame_ff <= tx_frame_in;
         crc_ok_ff   <= crc_ok_in;
         angle_ff    <= angle_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_tx_frame  = tx_frame_ff;
   assign rsp_crc_ok    = crc_ok_ff;
   assign rsp_angle_raw = angle_ff;

endmodule

### rtl/spi_sensor_frame_builder_crc8.sv
// Top level of the sensor SPI frame builder and reply checker.
// Instantiates sfb_front, sfb_queue and sfb_back; depends on sfb_pkg.
//
// Builds 8-byte command frames (memory read, EEPROM write, NOP, GET1) with
// the command code in byte 6 and a CRC-8 (poly 0x2F, init 0xFF, inverted)
// in byte 7, and checks reply frames (CRC match plus 14-bit raw angle).
// One request is accepted per cycle while req_stall is low, and one response
// comes out per request, through the queue register and then a two-stage
// CRC pipeline of four and three byte steps. req_stall rises only when the
// QUEUE_DEPTH-entry queue is full, which happens only after rsp_stall has held
// the back end. Command code registers are written through csr_*; the user
// must write them only while the block is idle, which the block itself does
// not enforce. csr_ready is always high and indexes beyond 3 are ignored.
module spi_sensor_frame_builder_crc8 import sfb_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_addr0,
   input  logic [15:0] req_addr1,
   input  logic [15:0] req_word_value,
   input  logic [7:0]  req_message_type,
   input  logic [63:0] req_rx_frame,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_tx_frame,
   output logic        rsp_crc_ok,
   output logic [13:0] rsp_angle_raw,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   entry_type front_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_push;
   logic      q_pop;
   logic      head_valid;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   sfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_addr0        (req_addr0),
      .req_addr1        (req_addr1),
      .req_word_value   (req_word_value),
      .req_message_type (req_message_type),
      .req_rx_frame     (req_rx_frame),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .entry            (front_entry)
   );

   sfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sfb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_tx_frame  (rsp_tx_frame),
      .rsp_crc_ok    (rsp_crc_ok),
      .rsp_angle_raw (rsp_angle_raw)
   );

endmodule

### rtl/sfb_checker.sv
// Port-level checks for the frame builder, bound to the top level.
// Depends only on the top level's ports.
module sfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_tx_frame,
   input logic        rsp_crc_ok,
   input logic [13:0] rsp_angle_raw,
   input logic        csr_ready
);

   // A stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_tx_frame) && $stable(rsp_crc_ok)
                                 && $stable(rsp_angle_raw))
      else $error("response payload changed while stalled");

   // A built frame never carries reply-check fields
   a_build_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_tx_frame != 64'd0) |-> !rsp_crc_ok && (rsp_angle_raw == 14'd0))
      else $error("built frame with check fields set");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Register port never pushes back
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready low");

endmodule

bind spi_sensor_frame_builder_crc8 sfb_checker u_sfb_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_tx_frame  (rsp_tx_frame),
   .rsp_crc_ok    (rsp_crc_ok),
   .rsp_angle_raw (rsp_angle_raw),
   .csr_ready     (csr_ready)
);

### sim/sfb_frame_checker.sv
`timescale 1ns / 100ps
// Response checker for the sensor frame builder: predicts each response from
// the accepted request and its own copy of the command code registers.
// Depends on sfb_pkg for the op and register index codes.
module sfb_frame_checker import sfb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_addr0,
   input  logic [15:0] req_addr1,
   input  logic [15:0] req_word_value,
   input  logic [7:0]  req_message_type,
   input  logic [63:0] req_rx_frame,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_tx_frame,
   input  logic        rsp_crc_ok,
   input  logic [13:0] rsp_angle_raw,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data,
   output int          mismatch_count,
   output int          responses_seen,
   output int          outstanding
);

   localparam logic [7:0] CRC_SEED = 8'hFF;
   localparam logic [7:0] CRC_TAPS = 8'h2F;

   // EEPROM write keys, indexed by address bits 5:1
   localparam logic [15:0] WRITE_KEYS [32] = '{
      16'd17485, 16'd31053, 16'd57190, 16'd57724,
      16'd7899,  16'd53543, 16'd26763, 16'd12528,
      16'd38105, 16'd51302, 16'd16209, 16'd24847,
      16'd13134, 16'd52339, 16'd14530, 16'd18350,
      16'd55636, 16'd64477, 16'd40905, 16'd45498,
      16'd24411, 16'd36677, 16'd4213,  16'd48843,
      16'd6368,  16'd5907,  16'd31384, 16'd63325,
      16'd3562,  16'd19816, 16'd6995,  16'd3147
   };

   typedef struct packed {
      logic [63:0] tx_frame;
      logic        crc_ok;
      logic [13:0] angle_raw;
   } frame_result_type;

   logic [7:0] mem_read_code = '0;
   logic [7:0] ee_write_code = '0;
   logic [7:0] nop_code      = '0;
   logic [7:0] get1_code     = '0;
   frame_result_type pending_frames [$];
   int fails = 0;
   int seen  = 0;

   // CRC-8 over bytes 0..6, byte 0 first, each byte MSB first, inverted at the end
   function automatic logic [7:0] frame_crc(logic [55:0] body);
      logic [7:0] c;
      logic       fb;
      c = CRC_SEED;
      for (int i = 0; i < 56; i++) begin
         fb = c[7] ^ body[8 * (i / 8) + 7 - (i % 8)];
         c = {c[6:0], 1'b0} ^ (fb ? CRC_TAPS : 8'h00);
      end
      return ~c;
   endfunction

   // Expected response for one request under the current command codes
   function automatic frame_result_type frame_for_request(logic [2:0] op, logic [15:0] a0,
         logic [15:0] a1, logic [15:0] w, logic [7:0] mt, logic [63:0] rx);
      frame_result_type r;
      logic [55:0] body;
      logic        build;
      r = '0;
      body = '0;
      build = 1'b1;
      case (op)
         OP_MEM_READ: body = {mem_read_code, 16'h0000, a1, a0};
         OP_EE_WRITE: body = {ee_write_code, w, WRITE_KEYS[a0[5:1]], 2'b00, a0[5:0], 8'h00};
         OP_NOP:      body = {nop_code, 16'h0000, w, 16'h0000};
         OP_GET1:     body = {mt | get1_code, 16'h0000, w[7:0], w[15:8], 16'h0000};
         OP_CHECK: begin
            r.crc_ok = (frame_crc(rx[55:0]) == rx[63:56]);
            r.angle_raw = rx[13:0];
            build = 1'b0;
         end
         default: build = 1'b0;
      endcase
      if (build) begin
         r.tx_frame = {frame_crc(body), body};
      end
      return r;
   endfunction

   // Track code writes, check responses against the oldest expectation, queue new ones
   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         mem_read_code = '0;
         ee_write_code = '0;
         nop_code = '0;
         get1_code = '0;
         pending_frames.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MEM_READ_CODE: mem_read_code = csr_data;
               CSR_EE_WRITE_CODE: ee_write_code = csr_data;
               CSR_NOP_CODE:      nop_code = csr_data;
               CSR_GET1_CODE:     get1_code = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (pending_frames.size() == 0) begin
               $error("response with no request outstanding");
               fails++;
            end else begin
               want = pending_frames.pop_front();
               if (rsp_tx_frame !== want.tx_frame) begin
                  $error("tx_frame mismatch: expected %h, actual %h",
                     want.tx_frame, rsp_tx_frame);
                  fails++;
               end
               if (rsp_crc_ok !== want.crc_ok) begin
                  $error("crc_ok mismatch: expected %b, actual %b", want.crc_ok, rsp_crc_ok);
                  fails++;
               end
               if (rsp_angle_raw !== want.angle_raw) begin
                  $error("angle_raw mismatch: expected %h, actual %h",
                     want.angle_raw, rsp_angle_raw);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_frames.push_back(frame_for_request(req_op, req_addr0, req_addr1,
               req_word_value, req_message_type, req_rx_frame));
         end
      end
      mismatch_count <= fails;
      responses_seen <= seen;
      outstanding <= pending_frames.size();
   end

endmodule

### sim/tb_spi_sensor_frame_builder_crc8.sv
`timescale 1ns / 100ps
// Testbench top for the sensor frame builder: drives requests, code writes
// and response stalls; sfb_frame_checker does the checking. Needs sfb_pkg.
module tb_spi_sensor_frame_builder_crc8;
   import sfb_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = OP_CHECK + 3'd1;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam logic [7:0] REPLY_SEED  = 8'hFF;
   localparam logic [7:0] REPLY_TAPS  = 8'h2F;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 192;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_op = '0;
   logic [15:0] req_addr0 = '0;
   logic [15:0] req_addr1 = '0;
   logic [15:0] req_word_value = '0;
   logic [7:0]  req_message_type = '0;
   logic [63:0] req_rx_frame = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_tx_frame;
   logic        rsp_crc_ok;
   logic [13:0] rsp_angle_raw;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   int idle_pct = 0;
   int stall_pct = 0;
   int requests_sent = 0;
   int mismatch_count;
   int responses_seen;
   int outstanding;

   always #2 clock = ~clock;

   spi_sensor_frame_builder_crc8 uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_addr0(req_addr0), .req_addr1(req_addr1), .req_word_value(req_word_value),
      .req_message_type(req_message_type), .req_rx_frame(req_rx_frame),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tx_frame(rsp_tx_frame),
      .rsp_crc_ok(rsp_crc_ok), .rsp_angle_raw(rsp_angle_raw),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   sfb_frame_checker frame_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_addr0(req_addr0), .req_addr1(req_addr1), .req_word_value(req_word_value),
      .req_message_type(req_message_type), .req_rx_frame(req_rx_frame),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_tx_frame(rsp_tx_frame),
      .rsp_crc_ok(rsp_crc_ok), .rsp_angle_raw(rsp_angle_raw),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatch_count(mismatch_count), .responses_seen(responses_seen),
      .outstanding(outstanding)
   );

   // Random receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Reply frame with a correct CRC in byte 7
   function automatic logic [63:0] sealed_reply(logic [55:0] body);
      logic [7:0] c;
      logic       fb;
      c = REPLY_SEED;
      for (int i = 0; i < 56; i++) begin
         fb = c[7] ^ body[8 * (i / 8) + 7 - (i % 8)];
         c = {c[6:0], 1'b0} ^ (fb ? REPLY_TAPS : 8'h00);
      end
      return {~c, body};
   endfunction

   // One request; returns at the edge where it is accepted
   task automatic send_request(logic [2:0] op, logic [15:0] a0, logic [15:0] a1,
         logic [15:0] w, logic [7:0] mt, logic [63:0] rx);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_addr0 <= a0;
      req_addr1 <= a1;
      req_word_value <= w;
      req_message_type <= mt;
      req_rx_frame <= rx;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Mostly legal ops; check requests mostly carry well-formed replies
   task automatic send_random_request();
      logic [2:0]  op;
      logic [55:0] body;
      logic [63:0] rx;
      int          pick;
      if ($urandom_range(99) < 96) begin
         op = 3'($urandom_range(OP_CHECK, OP_MEM_READ));
      end else begin
         op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      end
      body = 56'({$urandom(), $urandom()});
      pick = $urandom_range(99);
      if (pick < 55) begin
         rx = sealed_reply(body);
      end else if (pick < 85) begin
         rx = sealed_reply(body) ^ (64'd1 << $urandom_range(63));
      end else begin
         rx = {$urandom(), $urandom()};
      end
      send_request(op, 16'($urandom()), 16'($urandom()), 16'($urandom()),
         8'($urandom()), rx);
   endtask

   // Hold off requests until every response is back
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_code(logic [7:0] index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Code settings: all ones, all zeros, alternating, then random; plus one spare index
   task automatic load_codes(int setting);
      logic [7:0] value;
      for (int r = CSR_MEM_READ_CODE; r <= CSR_GET1_CODE; r++) begin
         case (setting)
            0:       value = 8'hFF;
            1:       value = 8'h00;
            2:       value = r[0] ? 8'hFF : 8'h00;
            default: value = 8'($urandom());
         endcase
         write_code(8'(r), value);
      end
      write_code(8'($urandom_range(255, CSR_GET1_CODE + 1)), 8'($urandom()));
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests under reset codes
      send_request(OP_MEM_READ, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0);
      send_request(OP_MEM_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
      send_request(OP_MEM_READ, 16'h1234, 16'hABCD, 16'h0000, 8'h00, '0);
      send_request(OP_EE_WRITE, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0);
      send_request(OP_EE_WRITE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
      send_request(OP_EE_WRITE, 16'h003E, 16'h0000, 16'hA5C3, 8'h00, '0);
      send_request(OP_EE_WRITE, 16'h0031, 16'h0000, 16'h5A3C, 8'h00, '0);
      send_request(OP_EE_WRITE, 16'h00C7, 16'h0000, 16'h8001, 8'h00, '0);
      send_request(OP_NOP, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0);
      send_request(OP_NOP, 16'h0000, 16'h0000, 16'hFFFF, 8'h00, '0);
      send_request(OP_GET1, 16'h0000, 16'h0000, 16'h1234, 8'h00, '0);
      send_request(OP_GET1, 16'h0000, 16'h0000, 16'hFFFF, 8'hFF, '0);
      send_request(OP_GET1, 16'h0000, 16'h0000, 16'h0000, 8'h5A, '0);
      send_request(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 8'h00, '0);
      send_request(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 8'h00, '1);
      send_request(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 8'h00, sealed_reply('1));
      send_request(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 8'h00,
         sealed_reply(56'h12_3456_789A_BCDE));
      send_request(OP_CHECK, 16'h0000, 16'h0000, 16'h0000, 8'h00,
         sealed_reply(56'h00_C0FF_EE00_3FFF) ^ (64'd1 << 63));
      for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++) begin
         send_request(3'(k), 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, '1);
      end

      // Random phases, each under new codes and one of four pacing modes
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_responses();
         load_codes(phase);
         case (phase % 4)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 56; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 56; end
            default: begin idle_pct = 10; stall_pct <= 10; end
         endcase
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(199) == 0) begin
               drain_responses();
            end
            send_random_request();
         end
      end

      drain_responses();
      stall_pct <= 0;
      repeat (8) @(posedge clock);
      $display("Sent %0d requests (all ops, spare ops, good and corrupt replies),",
         requests_sent);
      $display("checked %0d responses across %0d code settings and four pacing modes.",
         responses_seen, PHASES + 1);
      if (mismatch_count == 0) begin
         $display("PASS spi_sensor_frame_builder_crc8");
      end else begin
         $display("FAIL spi_sensor_frame_builder_crc8");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAIL spi_sensor_frame_builder_crc8");
      $finish;
   end

endmodule

### spi_sensor_frame_builder_crc8.f
rtl/sfb_pkg.sv
rtl/sfb_front.sv
rtl/sfb_queue.sv
rtl/sfb_back.sv
rtl/spi_sensor_frame_builder_crc8.sv
rtl/sfb_checker.sv
sim/sfb_frame_checker.sv
sim/tb_spi_sensor_frame_builder_crc8.sv
